// ===== design/packet_framer_crc8_macros.svh =====
// Assertion macros shared by the checker of the packet framer.
// Both expect a clock named i_clk and an active-low reset named i_rst_n.
`ifndef PACKET_FRAMER_CRC8_MACROS_SVH
`define PACKET_FRAMER_CRC8_MACROS_SVH

// Checked at every edge, reset included.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

// Checked only while out of reset.
`define PFC_ASSERT_NEXT_RUN(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and functions of the packet framer
// Item and result payloads, the command passed from front to back, the
// sequencer states and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_INIT  = 8'h00;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  pkt_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
    } t_result;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } t_cmd_kind;

    // For a start command, last means the packet has no payload; for a data
    // command, last means this byte closes the packet.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  pkt_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HEAD,
        ST_TYPE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_CRC
    } t_back_state;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/pfc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_fifo: small synchronous queue
// Register array with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module pfc_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== design/pfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_front: item classifier
// Tracks the open packet and its remaining payload count, drops stray payload
// items and turns the rest into commands for the back end.
// ----------------------------------------------------------------------------
module pfc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfc_pkg::t_item i_item,
    input  logic          i_cmd_full,
    output logic          o_cmd_push,
    output pfc_pkg::t_cmd o_cmd
);
    import pfc_pkg::*;

    logic        r_open, n_open;
    logic [15:0] r_remaining, n_remaining;
    logic        w_accept;

    assign w_accept = i_push && !i_cmd_full;

    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        o_cmd_push  = 1'b0;
        o_cmd.kind           = CMD_START;
        o_cmd.pkt_type       = i_item.pkt_type;
        o_cmd.payload_length = i_item.payload_length;
        o_cmd.data_byte      = i_item.data_byte;
        o_cmd.last           = (i_item.payload_length == '0);
        if (i_item.mode == MODE_START) begin
            o_cmd_push = w_accept;
            if (w_accept) begin
                n_open      = (i_item.payload_length != '0);
                n_remaining = i_item.payload_length;
            end
        end else begin
            o_cmd.kind = CMD_DATA;
            o_cmd.last = (r_remaining == 16'd1);
            // A payload item with no packet open is swallowed here.
            o_cmd_push = w_accept && r_open;
            if (w_accept && r_open) begin
                n_remaining = r_remaining - 16'd1;
                n_open      = (r_remaining != 16'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= '0;
        end else begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ===== design/pfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_back: byte sequencer
// Walks each command through its bytes, one per cycle while the result
// queue has room, with a running CRC-8, and holds the sync byte register.
// ----------------------------------------------------------------------------
module pfc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  pfc_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output pfc_pkg::t_result o_result
);
    import pfc_pkg::*;

    t_back_state r_state, n_state;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_sync_byte;
    logic        w_go;

    assign w_go = !i_out_full && (r_state != ST_HEAD || !i_cmd_empty);

    // Next state.
    always_comb begin
        n_state = r_state;
        if (w_go) begin
            case (r_state)
                ST_HEAD: begin
                    if (i_cmd.kind == CMD_START) begin
                        n_state = ST_TYPE;
                    end else if (i_cmd.last) begin
                        n_state = ST_CRC;
                    end
                end
                ST_TYPE:   n_state = ST_LEN_LO;
                ST_LEN_LO: n_state = ST_LEN_HI;
                ST_LEN_HI: n_state = i_cmd.last ? ST_CRC : ST_HEAD;
                ST_CRC:    n_state = ST_HEAD;
                default:   n_state = ST_HEAD;
            endcase
        end
    end

    // Outputs and CRC.
    always_comb begin
        o_out_push             = w_go;
        o_cmd_pop              = 1'b0;
        o_result.out_byte      = r_sync_byte;
        o_result.end_of_packet = 1'b0;
        n_crc                  = r_crc;
        case (r_state)
            ST_HEAD: begin
                if (i_cmd.kind == CMD_START) begin
                    // The sync byte is not covered by the CRC.
                    o_result.out_byte = r_sync_byte;
                    n_crc             = CRC_INIT;
                end else begin
                    o_result.out_byte = i_cmd.data_byte;
                    n_crc             = crc8_update(r_crc, i_cmd.data_byte);
                    o_cmd_pop         = w_go && !i_cmd.last;
                end
            end
            ST_TYPE: begin
                o_result.out_byte = i_cmd.pkt_type;
                n_crc             = crc8_update(r_crc, i_cmd.pkt_type);
            end
            ST_LEN_LO: begin
                o_result.out_byte = i_cmd.payload_length[7:0];
                n_crc             = crc8_update(r_crc, i_cmd.payload_length[7:0]);
            end
            ST_LEN_HI: begin
                o_result.out_byte = i_cmd.payload_length[15:8];
                n_crc             = crc8_update(r_crc, i_cmd.payload_length[15:8]);
                o_cmd_pop         = w_go && !i_cmd.last;
            end
            ST_CRC: begin
                o_result.out_byte      = r_crc;
                o_result.end_of_packet = 1'b1;
                n_crc                  = CRC_INIT;
                o_cmd_pop              = w_go;
            end
            default: begin
                o_out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HEAD;
            r_crc       <= CRC_INIT;
            r_sync_byte <= '0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_crc <= n_crc;
            end
            if (i_cfg_wr_en) begin
                r_sync_byte <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== design/packet_framer_crc8.sv =====
`timescale 1ns / 1ps
// An item goes as a command through the byte sequencer to the result queue.
// One payload item per cycle while neither queue is full; a start item holds the
// byte sequencer for its sync, type and both length bytes, plus the CRC byte
// when it has no payload; a closing payload item for its byte and the CRC byte.
// Reset is synchronous and clears both queues, the packet state and sync_byte.
// ----------------------------------------------------------------------------
// packet_framer_crc8: length-prefixed packet framer with CRC-8
// Front classifier, command queue, byte sequencer and result queue.
// ----------------------------------------------------------------------------
module packet_framer_crc8 #(
    parameter int CMD_DEPTH = pfc_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = pfc_pkg::OUT_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pfc_pkg::t_item   i_item,
    output logic             o_full,
    input  logic             i_pop,
    output pfc_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data
);
    import pfc_pkg::*;

    logic    w_cmd_push, w_cmd_pop, w_cmd_empty;
    t_cmd    w_cmd_in, w_cmd_out;
    logic    w_out_push, w_out_full;
    t_result w_res_in;

    pfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_cmd_full (o_full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    pfc_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(t_cmd))
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata (w_cmd_in),
        .o_full  (o_full),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    pfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd_out),
        .i_cmd_empty   (w_cmd_empty),
        .o_cmd_pop     (w_cmd_pop),
        .i_out_full    (w_out_full),
        .o_out_push    (w_out_push),
        .o_result      (w_res_in)
    );

    pfc_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_wdata (w_res_in),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_empty (o_empty)
    );

endmodule

// ===== design/pfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker: port-level checks for the packet framer
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
`include "packet_framer_crc8_macros.svh"

module pfc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_full,
    input logic             i_pop,
    input pfc_pkg::t_result o_result,
    input logic             o_empty
);

    // Reset must leave no result waiting and room for an item.
    `PFC_ASSERT_NEXT(a_reset_empty, !i_rst_n, o_empty, "result queue not empty after reset")
    `PFC_ASSERT_NEXT(a_reset_room, !i_rst_n, !o_full, "input full after reset")

    // A waiting result that is not taken stays on the ports unchanged.
    `PFC_ASSERT_NEXT_RUN(a_hold_result, !o_empty && !i_pop, !o_empty && $stable(o_result), "result changed before it was taken")

endmodule

bind packet_framer_crc8 pfc_checker u_pfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_full   (o_full),
    .i_pop    (i_pop),
    .o_result (o_result),
    .o_empty  (o_empty)
);

// ===== bench/packet_framer_crc8_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_framer_crc8_check: scoreboard for the packet framer
// Watches the item, result and register channels, keeps its own copy of the
// framing state and CRC, and compares every popped byte with the oldest
// expected one. Mismatches are counted and handed to the test top.
// ----------------------------------------------------------------------------
module packet_framer_crc8_check (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pfc_pkg::t_item   i_item,
    input  logic             i_full,
    input  logic             i_pop,
    input  pfc_pkg::t_result i_result,
    input  logic             i_empty,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    output int               o_errors,
    output int               o_pending
);
    import pfc_pkg::*;

    localparam logic [7:0] GEN_POLY = 8'h07;
    localparam logic [7:0] CRC_SEED = 8'h00;

    t_result     expected_bytes[$];
    logic [7:0]  sync_value;
    logic [7:0]  frame_crc;
    logic [15:0] bytes_left;
    logic        frame_open;

    function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ GEN_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    task automatic queue_byte(logic [7:0] b, logic last);
        t_result r;
        r.out_byte = b;
        r.end_of_packet = last;
        expected_bytes.push_back(r);
    endtask

    task automatic frame_item(t_item it);
        logic [7:0] hdr_crc;
        if (it.mode == MODE_START) begin
            // Any open packet is simply forgotten; the header restarts the CRC.
            queue_byte(sync_value, 1'b0);
            queue_byte(it.pkt_type, 1'b0);
            queue_byte(it.payload_length[7:0], 1'b0);
            queue_byte(it.payload_length[15:8], 1'b0);
            hdr_crc = crc8_step(CRC_SEED, it.pkt_type);
            hdr_crc = crc8_step(hdr_crc, it.payload_length[7:0]);
            hdr_crc = crc8_step(hdr_crc, it.payload_length[15:8]);
            if (it.payload_length == 16'd0) begin
                queue_byte(hdr_crc, 1'b1);
                frame_crc = CRC_SEED;
                bytes_left = 16'd0;
                frame_open = 1'b0;
            end else begin
                frame_crc = hdr_crc;
                bytes_left = it.payload_length;
                frame_open = 1'b1;
            end
        end else if (frame_open) begin
            queue_byte(it.data_byte, 1'b0);
            frame_crc = crc8_step(frame_crc, it.data_byte);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) begin
                queue_byte(frame_crc, 1'b1);
                frame_crc = CRC_SEED;
                frame_open = 1'b0;
            end
        end
    endtask

    task automatic check_byte(t_result got);
        t_result want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      got.out_byte, got.end_of_packet));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
        end
        if (got.end_of_packet !== want.end_of_packet) begin
            report_mismatch($sformatf("end_of_packet %0b, expected %0b",
                                      got.end_of_packet, want.end_of_packet));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            sync_value = 8'h00;
            frame_crc = CRC_SEED;
            bytes_left = 16'd0;
            frame_open = 1'b0;
        end else begin
            if (i_pop && !i_empty) begin
                check_byte(i_result);
            end
            if (i_cfg_wr_en) begin
                sync_value = i_cfg_wr_data;
            end
            if (i_push && !i_full) begin
                frame_item(i_item);
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// ===== bench/packet_framer_crc8_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_framer_crc8_test: stimulus and verdict for the packet framer
// Drives directed packets (empty, short, abandoned, stray payload bytes)
// and then random framed traffic under several sync byte settings, with
// bursty idling on both sides, one long receiver hold-off and a quiet tail.
// ----------------------------------------------------------------------------
module packet_framer_crc8_test;
    import pfc_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    t_item      item = '0;
    logic       full;
    logic       pop = 1'b0;
    t_result    result_bus;
    logic       empty;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    int errors;
    int pending;
    int idle_cycles = 0;
    int framed_items = 0;
    bit quiet = 1'b0;
    bit hold_rx = 1'b0;

    always #5 clk = ~clk;

    packet_framer_crc8 uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_item        (item),
        .o_full        (full),
        .i_pop         (pop),
        .o_result      (result_bus),
        .o_empty       (empty),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    packet_framer_crc8_check u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .i_item        (item),
        .i_full        (full),
        .i_pop         (pop),
        .i_result      (result_bus),
        .i_empty       (empty),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // Ends the run if neither side has moved an item for too long.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (hold_rx) begin
                // Long hold-off so that both queues fill and the input stalls.
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end else if (gap > 0) begin
                pop <= 1'b0;
                gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                gap = $urandom_range(0, 2);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic t_item noise_item(logic mode);
        t_item it;
        it.mode = mode;
        it.pkt_type = 8'($urandom);
        it.payload_length = 16'($urandom);
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    // Leaves push high on return, so a following item goes out back to back.
    task automatic offer(t_item it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            item <= noise_item(1'($urandom));
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
    endtask

    task automatic open_packet(logic [7:0] kind, logic [15:0] len);
        t_item it;
        it = noise_item(MODE_START);
        it.pkt_type = kind;
        it.payload_length = len;
        offer(it);
        framed_items++;
    endtask

    task automatic payload(logic [7:0] b);
        t_item it;
        it = noise_item(MODE_DATA);
        it.data_byte = b;
        offer(it);
        framed_items++;
    endtask

    task automatic stray_byte(logic [7:0] b);
        t_item it;
        it = noise_item(MODE_DATA);
        it.data_byte = b;
        offer(it);
    endtask

    // Waits until every expected byte has been popped and the block is quiet.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sync(logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_packet();
        int len;
        int sent;
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 2) begin
            len = 0;
        end else if (pick < 14) begin
            len = $urandom_range(1, 6);
        end else begin
            len = $urandom_range(7, 65535);
        end
        sent = len;
        // Long packets and some short ones are cut off by the next start.
        if (len > 6) begin
            sent = $urandom_range(0, 4);
        end else if (len > 0 && $urandom_range(0, 5) == 0) begin
            sent = $urandom_range(0, len - 1);
        end
        open_packet(8'($urandom), 16'(len));
        repeat (sent) payload(8'($urandom));
        if (sent == len && $urandom_range(0, 7) == 0) begin
            stray_byte(8'($urandom));
        end
    endtask

    task automatic random_phase(int count);
        int goal;
        goal = framed_items + count;
        while (framed_items < goal) random_packet();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the sync byte at its reset value.
        stray_byte(8'hFF);
        open_packet(8'h00, 16'h0000);
        open_packet(8'hFF, 16'h0000);
        settle();
        write_sync(8'hFF);
        open_packet(8'h5A, 16'h0001);
        payload(8'h00);
        open_packet(8'hA5, 16'h0002);
        payload(8'hFF);
        payload(8'h80);
        open_packet(8'h3C, 16'hFFFF);
        payload(8'h01);
        payload(8'h02);
        open_packet(8'hC3, 16'h8000);
        payload(8'h7F);
        open_packet(8'h11, 16'h0003);
        payload(8'hAA);
        payload(8'h55);
        payload(8'hFF);
        stray_byte(8'h12);

        settle();
        write_sync(8'h00);
        random_phase(22);

        settle();
        write_sync(8'($urandom));
        hold_rx = 1'b1;
        random_phase(22);

        settle();
        write_sync(8'($urandom));
        random_phase(22);

        settle();
        write_sync(8'hFF);
        quiet = 1'b1;
        random_phase(20);

        settle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
